FILE: src/ptt_pkg.sv
// shared constants for the periodic timer table
// opcodes, reset values and default parameter values; no dependencies
package ptt_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [31:0] DEFAULT_PERIOD_RST = 32'd1000;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_EXISTS = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

endpackage

FILE: src/periodic_timer_table.sv
// periodic timer table top level: control, scan sequencer and output register
// depends on ptt_pkg and ptt_slot_mem
//
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | opcode, slot, time_value, period
// out_    | output    | out_valid/out_stall | fired, fired_slot, exists, remaining, last
// cfg_    | input     | cfg_valid/cfg_ready | default_period word (cfg_data)
//
// start, stop, exists, clear and unused opcodes finish in the accepting cycle
// a next-deadline query makes one pass over the slot memory
// a tick makes one pass over the slot memory per fired slot plus a final one; each firing
// needs a full pass over the single memory read port to find the next minimum
// synchronous active-low reset clears armed bits, sequence counter and control;
// the slot memory needs no clearing pass
// in_stall is high while a query or tick is running, or while the output word is held
module periodic_timer_table #(
  parameter int NUM_SLOTS  = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_WIDTH = ptt_pkg::TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [3:0]         in_slot,
  input  logic [31:0]        in_time_value,
  input  logic [31:0]        in_period,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_fired,
  output logic [3:0]         out_fired_slot,
  output logic               out_exists,
  output logic signed [31:0] out_remaining,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW  = TIME_WIDTH;
  localparam int DW  = TW + 64;
  // adder width for deadline + period, one carry bit over the wider operand
  localparam int SUW = ((TW > 32) ? TW : 32) + 1;
  // width for the remaining-time saturation compare
  localparam int RW  = (TW > 33) ? TW : 33;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  typedef struct packed {
    logic [TW-1:0] dl;
    logic [31:0]   per;
    logic [31:0]   seq;
  } entry_t;

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt;
  logic [31:0]          seq_cnt_r, seq_cnt_nxt;
  logic [31:0]          dflt_per_r, dflt_per_nxt;
  logic                 issuing_r, issuing_nxt;
  logic [IW-1:0]        issue_idx_r, issue_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  logic                 prev_vld_r, prev_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload state
  logic [2:0]        op_r, op_nxt;
  logic [TW-1:0]     now_r, now_nxt;
  logic [TW-1:0]     best_dl_r, best_dl_nxt;
  logic [31:0]       best_per_r, best_per_nxt;
  logic [31:0]       best_seq_r, best_seq_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic [IW-1:0]     prev_idx_r, prev_idx_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic [3:0]        out_slot_r, out_slot_nxt;
  logic              out_exists_r, out_exists_nxt;
  logic [31:0]       out_rem_r, out_rem_nxt;
  logic              out_last_r, out_last_nxt;

  // memory port
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  ptt_slot_mem #(
    .DEPTH(NUM_SLOTS),
    .AW   (IW),
    .DW   (DW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(issue_idx_r),
    .rdata(mem_rdata)
  );

  // input decode
  logic [63:0]   tv64;
  logic [TW-1:0] tv;
  logic [7:0]    slot8;
  logic [IW-1:0] sidx;
  logic          slot_ok;
  logic [31:0]   start_per;
  logic          out_free;
  logic          in_acc;

  assign tv64      = {32'd0, in_time_value};
  assign tv        = tv64[TW-1:0];
  assign slot8     = {4'd0, in_slot};
  assign sidx      = slot8[IW-1:0];
  assign slot_ok   = 32'(in_slot) < 32'(NUM_SLOTS);
  assign start_per = (in_period == 32'd0) ? dflt_per_r : in_period;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // scan compare on the word just read
  logic cand;
  logic better;
  assign cand = (op_r == ptt_pkg::OP_TICK) ?
                (pend_r[rd_idx_r] && (mem_rdata.dl <= now_r)) : armed_r[rd_idx_r];
  assign better = !found_r || (mem_rdata.dl < best_dl_r) ||
                  ((mem_rdata.dl == best_dl_r) && (mem_rdata.seq < best_seq_r));

  // re-arm deadline, saturating at the largest time
  logic [SUW-1:0] sum;
  logic [TW-1:0]  new_dl;
  assign sum    = SUW'(best_dl_r) + SUW'(best_per_r);
  assign new_dl = (sum > SUW'({TW{1'b1}})) ? {TW{1'b1}} : sum[TW-1:0];

  // remaining time, saturated to a signed 32-bit word
  logic [TW-1:0] diff;
  logic [RW-1:0] diff_x;
  logic [31:0]   rem;
  always_comb begin
    diff   = (best_dl_r >= now_r) ? (best_dl_r - now_r) : (now_r - best_dl_r);
    diff_x = RW'(diff);
    if (best_dl_r >= now_r) begin
      rem = (diff_x > RW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : diff_x[31:0];
    end else begin
      rem = (diff_x >= RW'(32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - diff_x[31:0]);
    end
  end

  logic [7:0] prev8;
  assign prev8 = 8'(prev_idx_r);

  always_comb begin
    state_nxt      = state_r;
    armed_nxt      = armed_r;
    pend_nxt       = pend_r;
    seq_cnt_nxt    = seq_cnt_r;
    dflt_per_nxt   = dflt_per_r;
    issuing_nxt    = issuing_r;
    issue_idx_nxt  = issue_idx_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = issue_idx_r;
    found_nxt      = found_r;
    prev_vld_nxt   = prev_vld_r;
    out_valid_nxt  = out_valid_r && out_stall;
    op_nxt         = op_r;
    now_nxt        = now_r;
    best_dl_nxt    = best_dl_r;
    best_per_nxt   = best_per_r;
    best_seq_nxt   = best_seq_r;
    best_idx_nxt   = best_idx_r;
    prev_idx_nxt   = prev_idx_r;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_exists_nxt = out_exists_r;
    out_rem_nxt    = out_rem_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = sidx;
    mem_wdata      = '{dl: tv, per: start_per, seq: seq_cnt_r + 32'd1};

    if (cfg_valid && cfg_ready) begin
      dflt_per_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_opcode;
          now_nxt = tv;
          // default result word for single-result operations
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = 1'b0;
          out_slot_nxt   = 4'd0;
          out_exists_nxt = 1'b0;
          out_rem_nxt    = 32'd0;
          out_last_nxt   = 1'b1;
          unique case (in_opcode)
            ptt_pkg::OP_START: begin
              if (slot_ok) begin
                mem_we          = 1'b1;
                armed_nxt[sidx] = 1'b1;
                seq_cnt_nxt     = seq_cnt_r + 32'd1;
              end
            end
            ptt_pkg::OP_STOP: begin
              if (slot_ok) begin
                armed_nxt[sidx] = 1'b0;
              end
            end
            ptt_pkg::OP_EXISTS: begin
              out_exists_nxt = slot_ok && armed_r[sidx];
            end
            ptt_pkg::OP_CLEAR: begin
              armed_nxt = '0;
            end
            ptt_pkg::OP_TICK, ptt_pkg::OP_QUERY: begin
              // result comes after the scan
              out_valid_nxt = out_valid_r && out_stall;
              pend_nxt      = armed_r;
              prev_vld_nxt  = 1'b0;
              state_nxt     = ST_SCAN;
              issuing_nxt   = 1'b1;
              issue_idx_nxt = '0;
              found_nxt     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (issuing_r) begin
          rd_vld_nxt = 1'b1;
          if (issue_idx_r == LAST_IDX) begin
            issuing_nxt = 1'b0;
          end else begin
            issue_idx_nxt = issue_idx_r + IW'(1);
          end
        end
        if (rd_vld_r) begin
          if (cand && better) begin
            found_nxt    = 1'b1;
            best_dl_nxt  = mem_rdata.dl;
            best_per_nxt = mem_rdata.per;
            best_seq_nxt = mem_rdata.seq;
            best_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = ST_EVAL;
          end
        end
      end

      ST_EVAL: begin
        if (out_free) begin
          if (op_r == ptt_pkg::OP_QUERY) begin
            out_valid_nxt  = 1'b1;
            out_fired_nxt  = 1'b0;
            out_slot_nxt   = 4'd0;
            out_exists_nxt = 1'b0;
            out_rem_nxt    = found_r ? rem : 32'd0;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (found_r) begin
            // fire the minimum; its result is held until the next pass tells if it is last
            if (prev_vld_r) begin
              out_valid_nxt  = 1'b1;
              out_fired_nxt  = 1'b1;
              out_slot_nxt   = prev8[3:0];
              out_exists_nxt = 1'b0;
              out_rem_nxt    = 32'd0;
              out_last_nxt   = 1'b0;
            end
            pend_nxt[best_idx_r]  = 1'b0;
            armed_nxt[best_idx_r] = 1'b0;
            if (best_per_r != 32'd0) begin
              mem_we                = 1'b1;
              mem_waddr             = best_idx_r;
              mem_wdata             = '{dl: new_dl, per: best_per_r, seq: seq_cnt_r + 32'd1};
              armed_nxt[best_idx_r] = 1'b1;
              seq_cnt_nxt           = seq_cnt_r + 32'd1;
            end
            prev_vld_nxt  = 1'b1;
            prev_idx_nxt  = best_idx_r;
            state_nxt     = ST_SCAN;
            issuing_nxt   = 1'b1;
            issue_idx_nxt = '0;
            found_nxt     = 1'b0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_fired_nxt  = prev_vld_r;
            out_slot_nxt   = prev_vld_r ? prev8[3:0] : 4'd0;
            out_exists_nxt = 1'b0;
            out_rem_nxt    = 32'd0;
            out_last_nxt   = 1'b1;
            prev_vld_nxt   = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= '0;
      pend_r      <= '0;
      seq_cnt_r   <= 32'd0;
      dflt_per_r  <= ptt_pkg::DEFAULT_PERIOD_RST;
      issuing_r   <= 1'b0;
      issue_idx_r <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      found_r     <= 1'b0;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      pend_r      <= pend_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      dflt_per_r  <= dflt_per_nxt;
      issuing_r   <= issuing_nxt;
      issue_idx_r <= issue_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      found_r     <= found_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    now_r        <= now_nxt;
    best_dl_r    <= best_dl_nxt;
    best_per_r   <= best_per_nxt;
    best_seq_r   <= best_seq_nxt;
    best_idx_r   <= best_idx_nxt;
    prev_idx_r   <= prev_idx_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_exists_r <= out_exists_nxt;
    out_rem_r    <= out_rem_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_slot = out_slot_r;
  assign out_exists     = out_exists_r;
  assign out_remaining  = signed'(out_rem_r);
  assign out_last       = out_last_r;

  // read data only comes back during a pass
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("memory read data outside a scan pass");

  // a slot chosen to fire was still pending in this tick
  a_best_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && op_r == ptt_pkg::OP_TICK && found_r) |-> pend_r[best_idx_r])
    else $error("fired slot was not pending");

  // a fired slot never fires again in the same tick
  a_fire_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && op_r == ptt_pkg::OP_TICK && found_r && out_free)
    |=> !pend_r[$past(best_idx_r)])
    else $error("fired slot still pending");

endmodule

FILE: src/ptt_slot_mem.sv
// slot storage: one write port, one registered read port
// no package dependencies
module ptt_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sim/tb_periodic_timer_table.sv
// testbench for the periodic timer table: directed and random operation words
// depends on ptt_pkg and the periodic_timer_table rtl
`timescale 1ns / 100ps

module tb_periodic_timer_table;

  localparam int NSLOT = 16;
  localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic        exists;
    logic [31:0] remaining;
    logic        last;
  } timer_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_slot = '0;
  logic [31:0] in_time_value = '0;
  logic [31:0] in_period = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_fired;
  logic [3:0] out_fired_slot;
  logic out_exists;
  logic signed [31:0] out_remaining;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  periodic_timer_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_slot(in_slot), .in_time_value(in_time_value), .in_period(in_period),
    .out_valid(out_valid), .out_stall(out_stall), .out_fired(out_fired),
    .out_fired_slot(out_fired_slot), .out_exists(out_exists),
    .out_remaining(out_remaining), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the timer table
  logic [31:0] mdl_default;
  logic        mdl_armed [NSLOT];
  logic [31:0] mdl_deadline [NSLOT];
  logic [31:0] mdl_period [NSLOT];
  logic [31:0] mdl_seq [NSLOT];
  logic [31:0] mdl_seq_count;

  timer_word_t expected_words[$];
  int fail_count = 0;
  int words_seen = 0;
  int fired_seen = 0;
  bit hold_off = 1'b0;   // long receiver hold-off in progress
  int hold_cycles = 0;

  function automatic timer_word_t mk_word(logic f, logic [3:0] fs, logic ex,
                                         logic [31:0] rem, logic lst);
    timer_word_t w;
    w.fired = f; w.fired_slot = fs; w.exists = ex; w.remaining = rem; w.last = lst;
    return w;
  endfunction

  task automatic arm_timer(int s, logic [31:0] when, logic [31:0] per);
    mdl_seq_count = mdl_seq_count + 32'd1;
    mdl_armed[s] = 1'b1;
    mdl_deadline[s] = when;
    mdl_period[s] = per;
    mdl_seq[s] = mdl_seq_count;
  endtask

  // earliest deadline minus now, saturated to signed 32 bits
  function automatic logic [31:0] time_to_next(logic [31:0] now);
    bit any;
    logic [31:0] best;
    logic [32:0] d;
    any = 0; best = '0;
    for (int i = 0; i < NSLOT; i++)
      if (mdl_armed[i] && (!any || mdl_deadline[i] < best)) begin
        best = mdl_deadline[i]; any = 1;
      end
    if (!any) return '0;
    if (best >= now) begin
      d = best - now;
      return (d > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : d[31:0];
    end
    d = now - best;
    if (d >= 33'h8000_0000) return 32'h8000_0000;
    return 32'd0 - d[31:0];
  endfunction

  // work out the result words of one operation and update the model
  task automatic predict_timer_op(logic [2:0] op, logic [3:0] s, logic [31:0] tv,
                                  logic [31:0] per);
    bit elig [NSLOT];
    bit found;
    int b, n;
    logic [32:0] sum;
    timer_word_t w;
    case (op)
      ptt_pkg::OP_START: begin
        arm_timer(s, tv, (per == 0) ? mdl_default : per);
        expected_words.push_back(mk_word(0, 0, 0, 0, 1));
      end
      ptt_pkg::OP_STOP: begin
        mdl_armed[s] = 1'b0;
        expected_words.push_back(mk_word(0, 0, 0, 0, 1));
      end
      ptt_pkg::OP_EXISTS: expected_words.push_back(mk_word(0, 0, mdl_armed[s], 0, 1));
      ptt_pkg::OP_TICK: begin
        n = 0;
        for (int i = 0; i < NSLOT; i++) elig[i] = mdl_armed[i] && mdl_deadline[i] <= tv;
        forever begin
          found = 0; b = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (!elig[i]) continue;
            if (!found || mdl_deadline[i] < mdl_deadline[b] ||
                (mdl_deadline[i] == mdl_deadline[b] && mdl_seq[i] < mdl_seq[b])) begin
              b = i; found = 1;
            end
          end
          if (!found) break;
          elig[b] = 0;
          if (n > 0) begin
            w = expected_words.pop_back();
            w.last = 1'b0;
            expected_words.push_back(w);
          end
          expected_words.push_back(mk_word(1, 4'(b), 0, 0, 1));
          n++;
          mdl_armed[b] = 1'b0;
          if (mdl_period[b] != 0) begin
            sum = mdl_deadline[b] + mdl_period[b];
            arm_timer(b, sum[32] ? TMAX : sum[31:0], mdl_period[b]);
          end
        end
        if (n == 0) expected_words.push_back(mk_word(0, 0, 0, 0, 1));
      end
      ptt_pkg::OP_QUERY: expected_words.push_back(mk_word(0, 0, 0, time_to_next(tv), 1));
      ptt_pkg::OP_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) mdl_armed[i] = 1'b0;
        expected_words.push_back(mk_word(0, 0, 0, 0, 1));
      end
      default: expected_words.push_back(mk_word(0, 0, 0, 0, 1));
    endcase
  endtask

  // offer one operation word after a random gap, wait for acceptance
  // valid stays high into the next word when there is no gap
  task automatic send_op(logic [2:0] op, logic [3:0] s, logic [31:0] tv,
                         logic [31:0] per, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1; in_opcode <= op; in_slot <= s;
    in_time_value <= tv; in_period <= per;
    do @(posedge clk); while (in_stall);
    predict_timer_op(op, s, tv, per);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);   // extra margin; every tick also ends in a result word
  endtask

  // write default_period while the block is idle
  task automatic write_default(logic [31:0] val);
    wait_drained();
    cfg_valid <= 1'b1; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    mdl_default = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall per word, or a long hold-off when requested
  initial begin
    int stall_len;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_cycles++;
        if (hold_cycles >= 200) begin
          hold_off = 1'b0; out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (stall_len != 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    timer_word_t got, exp_w;
    if (rst_n && out_valid && !out_stall) begin
      got = mk_word(out_fired, out_fired_slot, out_exists, out_remaining, out_last);
      words_seen++;
      if (out_fired) fired_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          $display("%0t mismatch expected f=%0b s=%0d e=%0b r=%h l=%0b actual f=%0b s=%0d e=%0b r=%h l=%0b",
                   $time, exp_w.fired, exp_w.fired_slot, exp_w.exists, exp_w.remaining,
                   exp_w.last, got.fired, got.fired_slot, got.exists, got.remaining,
                   got.last);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  task automatic test_basic_ops();
    send_op(ptt_pkg::OP_QUERY, 0, 32'd5, 0);               // empty table answers zero
    send_op(ptt_pkg::OP_TICK, 0, TMAX, 0);                 // nothing fires
    send_op(ptt_pkg::OP_START, 0, 32'd100, 32'd0);         // zero period takes the default
    send_op(ptt_pkg::OP_START, 15, 32'd100, 32'd50);       // equal deadline, later sequence
    send_op(ptt_pkg::OP_EXISTS, 0, 0, 0);
    send_op(ptt_pkg::OP_EXISTS, 7, 0, 0);
    send_op(ptt_pkg::OP_QUERY, 0, 32'd40, 0);
    send_op(ptt_pkg::OP_QUERY, 0, 32'd300, 0);
    send_op(ptt_pkg::OP_TICK, 0, 32'd100, 0);
    send_op(ptt_pkg::OP_TICK, 0, 32'd5000, 0);             // re-armed slot fires once per tick
    send_op(ptt_pkg::OP_STOP, 15, 0, 0);
    send_op(ptt_pkg::OP_EXISTS, 15, 0, 0);
    send_op(ptt_pkg::OP_START, 3, TMAX - 5, TMAX);         // deadline saturates on re-arm
    send_op(ptt_pkg::OP_TICK, 0, TMAX, 0);
    send_op(ptt_pkg::OP_QUERY, 0, 32'd0, 0);               // positive remaining time, not saturated
    send_op(ptt_pkg::OP_START, 4, 32'd0, 32'd1);
    send_op(ptt_pkg::OP_QUERY, 0, TMAX, 0);                // saturated negative remaining
    send_op(3'd6, 5, rnd32(), rnd32());                    // unused opcodes
    send_op(3'd7, 10, rnd32(), rnd32());
    send_op(ptt_pkg::OP_CLEAR, 0, 0, 0);
    send_op(ptt_pkg::OP_EXISTS, 4, 0, 0);
  endtask

  task automatic test_one_shot();
    write_default(32'd0);                         // zero default: fires once then disarms
    send_op(ptt_pkg::OP_START, 9, 32'd10, 32'd0);
    send_op(ptt_pkg::OP_TICK, 0, 32'd20, 0);
    send_op(ptt_pkg::OP_EXISTS, 9, 0, 0);
    write_default(TMAX);
    send_op(ptt_pkg::OP_START, 1, 32'd7, 32'd0);
    send_op(ptt_pkg::OP_TICK, 0, 32'd7, 0);
    send_op(ptt_pkg::OP_QUERY, 0, 32'd7, 0);
  endtask

  // arm all slots then fire them in one tick
  task automatic test_full_tick();
    for (int i = 0; i < NSLOT; i++)
      send_op(ptt_pkg::OP_START, 4'(i), $urandom_range(0, 40), 32'd3, 1);
    send_op(ptt_pkg::OP_TICK, 0, 32'd40, 0);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 0; hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      send_op(ptt_pkg::OP_EXISTS, 4'($urandom_range(0, 15)), 0, 0, 1);
    wait_drained();                               // sender pauses until all results arrive
  endtask

  task automatic test_random(int count);
    int r;
    logic [31:0] base;
    base = $urandom_range(0, 1000);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_op(ptt_pkg::OP_START, 4'($urandom()), ($urandom_range(0, 7) == 0) ? rnd32()
                : base + $urandom_range(0, 300),
                ($urandom_range(0, 4) == 0) ? 32'd0
                : (($urandom_range(0, 7) == 0) ? rnd32() : $urandom_range(1, 200)));
      else if (r < 60) begin
        base = base + $urandom_range(0, 250);
        send_op(ptt_pkg::OP_TICK, 4'($urandom()),
                ($urandom_range(0, 15) == 0) ? rnd32() : base, rnd32());
      end else if (r < 70) send_op(ptt_pkg::OP_STOP, 4'($urandom()), rnd32(), rnd32());
      else if (r < 80) send_op(ptt_pkg::OP_EXISTS, 4'($urandom()), rnd32(), rnd32());
      else if (r < 92)
        send_op(ptt_pkg::OP_QUERY, 4'($urandom()),
                ($urandom_range(0, 3) == 0) ? rnd32() : base, rnd32());
      else if (r < 96) send_op(ptt_pkg::OP_CLEAR, 4'($urandom()), rnd32(), rnd32());
      else send_op(3'($urandom_range(6, 7)), 4'($urandom()), rnd32(), rnd32());
    end
  endtask

  initial begin
    mdl_default = ptt_pkg::DEFAULT_PERIOD_RST;
    mdl_seq_count = '0;
    for (int i = 0; i < NSLOT; i++) begin
      mdl_armed[i] = 0; mdl_deadline[i] = 0; mdl_period[i] = 0; mdl_seq[i] = 0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_one_shot();
    write_default(32'd1);
    test_full_tick();
    test_backpressure();
    write_default(32'd25);
    test_random(107);
    write_default($urandom_range(1, 500));
    test_random(107);
    wait_drained();
    $display("covered all opcodes, full-table ticks, saturation, one-shot timers and hold-off");
    $display("%0d result words checked, %0d firings", words_seen, fired_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
